// ===== rtl/btda_pkg.sv =====
`timescale 1ns / 1ps

package btda_pkg;

  localparam int VALUE_W        = 31;
  localparam int BYTE_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS_DEF = 12;

  // Reciprocal of ten: q = (x * RECIP) >> RECIP_SHIFT is exact for x < 2**32.
  localparam int                RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP      = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;
  localparam int                QUO_W       = VALUE_W + RECIP_W - RECIP_SHIFT;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] BYTE_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_LF   = 8'd10;

  localparam logic [1:0] SEL_DIGIT = 2'd0;
  localparam logic [1:0] SEL_CR    = 2'd1;
  localparam logic [1:0] SEL_LF    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div;
    logic       emit;
    logic [1:0] sel;
  } btda_cmd_t;

  typedef struct packed {
    logic out_free;
  } btda_status_t;

endpackage

// ===== rtl/btda_ctrl.sv =====
`timescale 1ns / 1ps

module btda_ctrl #(
  parameter int NUM_DIGITS = btda_pkg::NUM_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  btda_pkg::btda_status_t status,
  output btda_pkg::btda_cmd_t    cmd
);
  import btda_pkg::*;

  localparam int CNT_W = $clog2(NUM_DIGITS + 2);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_DIGITS - 1);
  localparam logic [CNT_W-1:0] CR_POS   = CNT_W'(NUM_DIGITS);
  localparam logic [CNT_W-1:0] LF_POS   = CNT_W'(NUM_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = SEL_DIGIT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (cnt_r == LF_POS)      cmd.sel = SEL_LF;
        else if (cnt_r == CR_POS) cmd.sel = SEL_CR;
        // advance only when the output register can take a beat
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == LF_POS) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/btda_datapath.sv =====
`timescale 1ns / 1ps

module btda_datapath #(
  parameter int NUM_DIGITS = btda_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [btda_pkg::VALUE_W-1:0]  in_value,
  input  btda_pkg::btda_cmd_t           cmd,
  output btda_pkg::btda_status_t        status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btda_pkg::BYTE_W-1:0]   out_char_byte,
  output logic                          out_last
);
  import btda_pkg::*;

  localparam int PROD_W = VALUE_W + RECIP_W;

  logic [VALUE_W-1:0] value_r;
  logic [DIGIT_W-1:0] digits_r [NUM_DIGITS];
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;
  logic               valid_r;

  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [DIGIT_W-1:0] quo_x10_lo;
  logic [DIGIT_W-1:0] digit;
  logic [BYTE_W-1:0]  byte_nxt;

  // Only the low nibble of x - 10*q is needed: the remainder is below ten.
  assign prod       = {{RECIP_W{1'b0}}, value_r} * {{VALUE_W{1'b0}}, RECIP};
  assign quo        = prod[RECIP_SHIFT +: QUO_W];
  assign quo_x10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign digit      = value_r[DIGIT_W-1:0] - quo_x10_lo;

  always_comb begin
    unique case (cmd.sel)
      SEL_DIGIT: byte_nxt = BYTE_ZERO + {{(BYTE_W-DIGIT_W){1'b0}}, digits_r[NUM_DIGITS-1]};
      SEL_CR:    byte_nxt = BYTE_CR;
      SEL_LF:    byte_nxt = BYTE_LF;
      default:   byte_nxt = BYTE_LF;
    endcase
  end

  assign status.out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
    end else if (cmd.div) begin
      value_r <= {{(VALUE_W-QUO_W){1'b0}}, quo};
    end
  end

  // Digits enter at the top, so the most significant one ends up there.
  always_ff @(posedge clk) begin
    if (cmd.div) begin
      digits_r[NUM_DIGITS-1] <= digit;
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
        digits_r[i] <= digits_r[i+1];
      end
    end else if (cmd.emit && cmd.sel == SEL_DIGIT) begin
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
        digits_r[i+1] <= digits_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_r <= byte_nxt;
      last_r <= (cmd.sel == SEL_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid     = valid_r;
  assign out_char_byte = byte_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/binary_to_decimal_ascii_serializer_unit.sv =====
`timescale 1ns / 1ps
// Prints a 31-bit unsigned number as a fixed-width decimal line in ASCII.
// Input channel: in_value with in_valid / in_stall; a beat is taken when
// in_valid is high and in_stall is low.
// Output channel: out_char_byte and out_last with out_valid / out_stall; one
// beat per byte: NUM_DIGITS digits, most significant first with leading
// zeros, then CR, then LF with out_last set.
// Timing: after a number is taken, the digit extraction runs one reciprocal
// multiply by ten per cycle, one per digit, before the first byte is emitted.
// Bytes then leave one per cycle while the receiver does not stall.
// A new number is taken once the LF byte is loaded into the output register,
// not while a line is still being converted or emitted.
// When the receiver stalls, the held byte stays put and the block waits;
// in_stall stays high until the whole line has gone to the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register; no clearing pass is needed.
module binary_to_decimal_ascii_serializer_unit #(
  parameter int NUM_DIGITS = btda_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [btda_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [btda_pkg::BYTE_W-1:0]  out_char_byte,
  output logic                         out_last
);
  import btda_pkg::*;

  btda_cmd_t    cmd;
  btda_status_t status;

  btda_ctrl #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  btda_datapath #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_byte(out_char_byte),
    .out_last     (out_last)
  );

endmodule

// ===== rtl/btda_checker.sv =====
`timescale 1ns / 1ps

module btda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_byte,
  input logic       out_last
);

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char_byte == 8'd10)
    else $error("last beat is not a line feed");

  a_body_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      (out_char_byte >= 8'd48 && out_char_byte <= 8'd57) || out_char_byte == 8'd13)
    else $error("unexpected byte in line body");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while converting");

endmodule

bind binary_to_decimal_ascii_serializer_unit btda_checker u_btda_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char_byte(out_char_byte),
  .out_last     (out_last)
);

// ===== tb/btda_line_checker.sv =====
`timescale 1ns / 1ps

module btda_line_checker #(
  parameter int NUM_DIGITS = btda_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [btda_pkg::VALUE_W-1:0] in_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [btda_pkg::BYTE_W-1:0]  out_char_byte,
  input  logic                         out_last,
  output int                           mismatch_count,
  output int                           pending_beats
);
  import btda_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              last;
  } line_beat_t;

  line_beat_t expected_line_q [$];

  initial begin
    mismatch_count = 0;
    pending_beats  = 0;
  end

  // Queue the full ASCII line for one number: digits MSB first, then CR, LF.
  function automatic void predict_line(input logic [VALUE_W-1:0] number);
    logic [VALUE_W-1:0] rest;
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    line_beat_t         beat;
    rest = number;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      digits[d] = DIGIT_W'(rest % 10);
      rest      = VALUE_W'(rest / 10);
    end
    for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
      beat.char_byte = BYTE_ZERO + BYTE_W'(digits[d]);
      beat.last      = 1'b0;
      expected_line_q.push_back(beat);
    end
    beat.char_byte = BYTE_CR;
    beat.last      = 1'b0;
    expected_line_q.push_back(beat);
    beat.char_byte = BYTE_LF;
    beat.last      = 1'b1;
    expected_line_q.push_back(beat);
  endfunction

  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_line(in_value);
      end
      if (out_valid && !out_stall) begin
        if (expected_line_q.size() == 0) begin
          $error("out beat with nothing expected: out_char_byte %0d, out_last %0d",
                 out_char_byte, out_last);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_line_q.pop_front();
          if (out_char_byte !== want.char_byte) begin
            $error("out_char_byte: expected %0d, got %0d", want.char_byte, out_char_byte);
            mismatch_count = mismatch_count + 1;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      pending_beats = expected_line_q.size();
    end
  end

endmodule

// ===== tb/binary_to_decimal_ascii_serializer_unit_tb.sv =====
`timescale 1ns / 1ps

module binary_to_decimal_ascii_serializer_unit_tb;
  import btda_pkg::*;

  localparam int RANDOM_NUMBERS = 410;
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_char_byte;
  logic               out_last;

  int mismatch_count;
  int pending_beats;
  int idle_cycles = 0;
  int stall_left  = 0;
  int stall_pick;
  bit calm_phase  = 1'b0;

  logic [VALUE_W-1:0] directed_values [$] = '{
    31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd99, 31'd100, 31'd999, 31'd1000,
    31'd12345, 31'd99999, 31'd100000, 31'd999999, 31'd1000000, 31'd9999999,
    31'd99999999, 31'd100000000, 31'd999999999, 31'd1000000000,
    31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA
  };

  binary_to_decimal_ascii_serializer_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_byte (out_char_byte),
    .out_last      (out_last)
  );

  btda_line_checker i_line_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_byte  (out_char_byte),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver backpressure: mostly short runs, the odd long stall.
  always @(posedge clk) begin
    if (calm_phase) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 15);
      end else if (stall_pick < 88) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(3, 9);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(20, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Hold the beat until it is taken, then idle for the requested gap.
  task automatic send_value(input logic [VALUE_W-1:0] number, input int gap);
    in_valid <= 1'b1;
    in_value <= number;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_beats == 0);
  endtask

  initial begin
    logic [VALUE_W-1:0] number;
    logic [VALUE_W-1:0] tenpow;
    int                 gap;
    int                 k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) begin
      send_value(directed_values[i], next_gap());
    end
    drain_lines();

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      calm_phase <= (n >= 150 && n < 210);
      if (n % 100 == 50) begin
        drain_lines();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: number = VALUE_W'($urandom);
        4, 5:       number = VALUE_W'($urandom_range(0, 999));
        6, 7: begin
          // land on a digit boundary: 10^k - 1, 10^k or 10^k + 1
          k      = $urandom_range(0, 9);
          tenpow = VALUE_W'(1);
          repeat (k) tenpow = VALUE_W'(tenpow * 10);
          case ($urandom_range(0, 2))
            0:       number = VALUE_W'(tenpow - 1);
            1:       number = tenpow;
            default: number = VALUE_W'(tenpow + 1);
          endcase
        end
        8:       number = VALUE_W'($urandom) >> $urandom_range(1, 30);
        default: number = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 255));
      endcase
      gap = (n >= 150 && n < 210) ? 0 : next_gap();
      send_value(number, gap);
    end

    drain_lines();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/btda_pkg.sv
rtl/btda_ctrl.sv
rtl/btda_datapath.sv
rtl/binary_to_decimal_ascii_serializer_unit.sv
rtl/btda_checker.sv
tb/btda_line_checker.sv
tb/binary_to_decimal_ascii_serializer_unit_tb.sv
